FILE: design/siphash_128_fixed_16_byte_core_macros.svh
// assertion macros for the siphash 128-bit core
// used by the top level only, no other dependencies
`ifndef SIPHASH_128_FIXED_16_BYTE_CORE_MACROS_SVH
`define SIPHASH_128_FIXED_16_BYTE_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SH128_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sh128 assertion failed");

// next-cycle implication, disabled while in reset
`define SH128_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sh128 assertion failed");

`endif

FILE: design/sh128_pkg.sv
// shared types, constants and round function for the siphash 128-bit core
// no dependencies
package sh128_pkg;

  localparam int unsigned CompressRounds = 2;
  localparam int unsigned FinalRounds    = 4;
  localparam int unsigned NumWords       = 3;
  localparam int unsigned NUM_ROUNDS     = NumWords * CompressRounds + 2 * FinalRounds;

  localparam logic [63:0] INIT_A       = 64'h736f6d6570736575;
  localparam logic [63:0] INIT_B       = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT_C       = 64'h6c7967656e657261;
  localparam logic [63:0] INIT_D       = 64'h7465646279746573;
  localparam logic [63:0] TWEAK_WIDE   = 64'h00000000000000ee;
  localparam logic [63:0] TWEAK_SECOND = 64'h00000000000000dd;
  localparam logic [63:0] LEN_WORD     = 64'd16 << 56;

  // configuration register indexes
  localparam logic [0:0] REG_KEY_LOW  = 1'b0;
  localparam logic [0:0] REG_KEY_HIGH = 1'b1;

  typedef enum logic [1:0] {
    WSEL_NONE,
    WSEL_M0,
    WSEL_M1,
    WSEL_LEN
  } word_sel_t;

  // what a stage does to the lanes before its round
  typedef struct packed {
    word_sel_t xor_a;
    word_sel_t xor_d;
    logic      xor_c_tweak;
    logic      xor_b_tweak;
    logic      save_h0;
  } stage_op_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
    logic [63:0] m0;
    logic [63:0] m1;
    logic [63:0] h0;
  } item_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (64 - n));
  endfunction

  function automatic item_t mix_round(input item_t s);
    item_t t;
    t = s;
    t.a = t.a + t.b;
    t.b = rotl(t.b, 13);
    t.b = t.b ^ t.a;
    t.a = rotl(t.a, 32);
    t.c = t.c + t.d;
    t.d = rotl(t.d, 16);
    t.d = t.d ^ t.c;
    t.a = t.a + t.d;
    t.d = rotl(t.d, 21);
    t.d = t.d ^ t.a;
    t.c = t.c + t.b;
    t.b = rotl(t.b, 17);
    t.b = t.b ^ t.c;
    t.c = rotl(t.c, 32);
    return t;
  endfunction

  function automatic logic [63:0] pick_word(input word_sel_t sel, input item_t s);
    logic [63:0] w;
    case (sel)
      WSEL_M0:  w = s.m0;
      WSEL_M1:  w = s.m1;
      WSEL_LEN: w = LEN_WORD;
      default:  w = '0;
    endcase
    return w;
  endfunction

  function automatic word_sel_t word_code(input int unsigned j);
    word_sel_t w;
    case (j)
      0:       w = WSEL_M0;
      1:       w = WSEL_M1;
      default: w = WSEL_LEN;
    endcase
    return w;
  endfunction

  // stage k runs round k; absorb and tweak steps sit in front of the round
  function automatic stage_op_t stage_op(input int unsigned k);
    stage_op_t op;
    op = '{xor_a: WSEL_NONE, xor_d: WSEL_NONE, xor_c_tweak: 1'b0,
           xor_b_tweak: 1'b0, save_h0: 1'b0};
    if (k < NumWords * CompressRounds) begin
      if (k % CompressRounds == 0) begin
        op.xor_d = word_code(k / CompressRounds);
        if (k != 0) op.xor_a = word_code(k / CompressRounds - 1);
      end
    end else if (k == NumWords * CompressRounds) begin
      op.xor_a       = word_code(NumWords - 1);
      op.xor_c_tweak = 1'b1;
    end else if (k == NumWords * CompressRounds + FinalRounds) begin
      op.save_h0     = 1'b1;
      op.xor_b_tweak = 1'b1;
    end
    return op;
  endfunction

endpackage

FILE: design/sh128_in_if.sv
// request channel carrying one 16-byte message as two 64-bit words
// no dependencies
interface sh128_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_low;
  logic [63:0] data_high;

  modport source (output valid, data_low, data_high, input ready);
  modport sink (input valid, data_low, data_high, output ready);
endinterface

FILE: design/sh128_out_if.sv
// result channel carrying the 128-bit hash as two 64-bit words
// no dependencies
interface sh128_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_low;
  logic [63:0] hash_high;

  modport source (output valid, hash_low, hash_high, input ready);
  modport sink (input valid, hash_low, hash_high, output ready);
endinterface

FILE: design/sh128_round.sv
// one pipeline stage: optional absorb/tweak step, one sip round, register
// depends on sh128_pkg
module sh128_round (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  sh128_pkg::stage_op_t  op,
  input  logic                  in_valid,
  input  sh128_pkg::item_t      in_item,
  output logic                  valid_r,
  output sh128_pkg::item_t      item_r
);

  sh128_pkg::item_t pre;
  sh128_pkg::item_t item_nxt;
  logic             valid_nxt;

  always_comb begin
    pre   = in_item;
    pre.a = pre.a ^ sh128_pkg::pick_word(op.xor_a, in_item);
    pre.d = pre.d ^ sh128_pkg::pick_word(op.xor_d, in_item);
    if (op.xor_c_tweak) pre.c = pre.c ^ sh128_pkg::TWEAK_WIDE;
    // first hash word is taken before the second finalization tweak
    if (op.save_h0) pre.h0 = in_item.a ^ in_item.b ^ in_item.c ^ in_item.d;
    if (op.xor_b_tweak) pre.b = pre.b ^ sh128_pkg::TWEAK_SECOND;
    item_nxt  = sh128_pkg::mix_round(pre);
    valid_nxt = en ? in_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: design/siphash_128_fixed_16_byte_core.sv
// SipHash-2-4 with 128-bit output over a fixed 16-byte message. One message
// is accepted per clock while the pipeline advances; each result passes
// through one register stage per sip round (14 rounds, the first loaded at
// the accepting edge) and then the output register. The whole pipeline advances
// together and freezes while a result waits on out_chan, so throughput is one
// item per cycle whenever the result side keeps ready high. Keys must be written
// through cfg_* only while the pipeline is empty (the core itself does not enforce
// this); index 0 is key bytes 0..7, index 1 key bytes 8..15.
// depends on sh128_pkg, sh128_in_if, sh128_out_if, sh128_round and the macros header
`include "siphash_128_fixed_16_byte_core_macros.svh"

module siphash_128_fixed_16_byte_core (
  input  logic        clk,
  input  logic        rst_n,
  sh128_in_if.sink    in_chan,
  sh128_out_if.source out_chan,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int unsigned N = sh128_pkg::NUM_ROUNDS;

  logic [63:0] key_low_r,  key_low_nxt;
  logic [63:0] key_high_r, key_high_nxt;

  logic             advance;
  sh128_pkg::item_t init_item;
  logic             stage_valid [N];
  sh128_pkg::item_t stage_item  [N];

  logic        out_valid_r, out_valid_nxt;
  logic [63:0] hash_low_r;
  logic [63:0] hash_high_r;

  // key registers
  always_comb begin
    key_low_nxt  = key_low_r;
    key_high_nxt = key_high_r;
    if (cfg_we) begin
      unique case (cfg_index)
        sh128_pkg::REG_KEY_LOW:  key_low_nxt  = cfg_wdata;
        sh128_pkg::REG_KEY_HIGH: key_high_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else begin
      key_low_r  <= key_low_nxt;
      key_high_r <= key_high_nxt;
    end
  end

  // whole pipeline moves unless a finished result is stuck at the output
  assign advance       = !out_valid_r || out_chan.ready;
  assign in_chan.ready = advance;

  always_comb begin
    init_item.a  = sh128_pkg::INIT_A ^ key_low_r;
    init_item.b  = sh128_pkg::INIT_B ^ key_high_r ^ sh128_pkg::TWEAK_WIDE;
    init_item.c  = sh128_pkg::INIT_C ^ key_low_r;
    init_item.d  = sh128_pkg::INIT_D ^ key_high_r;
    init_item.m0 = in_chan.data_low;
    init_item.m1 = in_chan.data_high;
    init_item.h0 = '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    if (k == 0) begin : g_first
      sh128_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .op       (sh128_pkg::stage_op(k)),
        .in_valid (in_chan.valid),
        .in_item  (init_item),
        .valid_r  (stage_valid[k]),
        .item_r   (stage_item[k])
      );
    end else begin : g_rest
      sh128_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .op       (sh128_pkg::stage_op(k)),
        .in_valid (stage_valid[k-1]),
        .in_item  (stage_item[k-1]),
        .valid_r  (stage_valid[k]),
        .item_r   (stage_item[k])
      );
    end
  end

  // output register, second hash word folded here
  assign out_valid_nxt = advance ? stage_valid[N-1] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hash_low_r  <= stage_item[N-1].h0;
      hash_high_r <= stage_item[N-1].a ^ stage_item[N-1].b ^
                     stage_item[N-1].c ^ stage_item[N-1].d;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.hash_low  = hash_low_r;
  assign out_chan.hash_high = hash_high_r;

  `SH128_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_chan.valid && in_chan.ready, stage_valid[0])
  `SH128_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !advance, $stable(stage_valid[N-1]) && $stable(stage_valid[0]))
  `SH128_ASSERT_NOW(a_out_from_last, clk, rst_n, $rose(out_valid_r), $past(stage_valid[N-1]))
  `SH128_ASSERT_NOW(a_stall_blocks_in, clk, rst_n, out_valid_r && !out_chan.ready, !in_chan.ready)

endmodule
